// ===== src/aba_pkg.sv =====
// ----------------------------------------------------------------------------
// aba_pkg
// Shared constants for the ambient brightness averager: register indexes,
// reset values and field widths.
// ----------------------------------------------------------------------------
package aba_pkg;

	localparam int WINDOW_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int VALUE_W    = 8;
	localparam int COUNT_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS  = 2'd1;

	localparam logic [COUNT_W-1:0] SAMPLE_INTERVAL_RST = 16'd800;
	localparam logic [VALUE_W-1:0] MIN_BRIGHTNESS_RST  = 8'd10;
	localparam logic [VALUE_W-1:0] BRIGHTNESS_RST      = 8'd255;
	localparam logic [VALUE_W-1:0] VALUE_MAX           = 8'hFF;

endpackage

// ===== src/ambient_brightness_averager.sv =====
// ----------------------------------------------------------------------------
// ambient_brightness_averager
// Averages inverted light readings over a ring of WINDOW samples and
// delivers the display dimming compare value for every PWM tick.
// ----------------------------------------------------------------------------
// Every request is one PWM tick and yields one result. The block takes one
// request per clock while the output side keeps up and presents its result
// through three pipeline stages. The sample ring sits in a synchronous memory
// read when a request is accepted; the running sum is updated in the next
// stage by subtracting the overwritten entry and adding the new one, and the
// division by WINDOW is a multiplication by a reciprocal in the final stage.
// The ring reads as zero after reset through one valid bit per entry, so no
// clearing pass is needed. Configuration writes are taken on every cycle.
module ambient_brightness_averager #(
	parameter int WINDOW = aba_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          sensor_ready,
	input  logic [aba_pkg::VALUE_W-1:0]   sensor_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [aba_pkg::VALUE_W-1:0]   pwm_compare,
	output logic                          start_conversion
);
	import aba_pkg::*;

	localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W   = $clog2(255 * WINDOW + 1);
	localparam int SHIFT   = SUM_W + IDX_W;
	localparam int MUL_W   = SUM_W + 1;
	localparam int PROD_W  = SUM_W + MUL_W;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(((64'd1 << SHIFT) + WINDOW - 1) / WINDOW);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	logic [COUNT_W-1:0] sample_interval_q;
	logic [VALUE_W-1:0] min_brightness_q;
	logic [COUNT_W-1:0] tick_count_q;
	logic [IDX_W-1:0]   wi_q;
	logic [WINDOW-1:0]  ring_vld_q;
	logic [SUM_W-1:0]   sum_q;
	logic [VALUE_W-1:0] brightness_q;

	logic [VALUE_W-1:0] ring_mem [WINDOW];

	logic               vld_s1, take_s1, old_vld_s1;
	logic [VALUE_W-1:0] level_s1, old_s1;
	logic [IDX_W-1:0]   addr_s1;
	logic               vld_s2, take_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic               vld_s3, start_s3;
	logic [VALUE_W-1:0] pwm_s3;

	logic               acc, hit, rdy2, rdy3, adv2, adv3, wr_en;
	logic [VALUE_W-1:0] inv, level_in, old_val;
	logic [IDX_W-1:0]   wi_next;
	logic [SUM_W-1:0]   sum_new;
	logic [PROD_W-1:0]  product;
	logic [VALUE_W-1:0] quot;

	// Each stage frees up when empty or when it hands its request onward.
	assign rdy3     = !vld_s3 || out_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign in_ready = !vld_s1 || rdy2;
	assign adv2     = vld_s1 && rdy2;
	assign adv3     = vld_s2 && rdy3;
	assign acc      = in_valid && in_ready;
	assign wr_en    = adv2 && take_s1;

	assign cfg_ready = 1'b1;

	assign hit      = sensor_ready && (tick_count_q == sample_interval_q);
	assign inv      = VALUE_MAX - sensor_value;
	assign level_in = (inv < min_brightness_q) ? min_brightness_q : inv;
	assign wi_next  = (wi_q == LAST_IDX) ? '0 : wi_q + 1'b1;

	assign old_val = old_vld_s1 ? old_s1 : '0;
	assign sum_new = sum_q - SUM_W'(old_val) + SUM_W'(level_s1);

	assign product = PROD_W'(sum_s2) * PROD_W'(RECIP);
	assign quot    = product[SHIFT +: VALUE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_interval_q <= SAMPLE_INTERVAL_RST;
			min_brightness_q  <= MIN_BRIGHTNESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAMPLE_INTERVAL: begin
					sample_interval_q <= cfg_data;
				end
				REG_MIN_BRIGHTNESS: begin
					min_brightness_q <= cfg_data[VALUE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			wi_q         <= '0;
			ring_vld_q   <= '0;
			sum_q        <= '0;
			brightness_q <= BRIGHTNESS_RST;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
		end else begin
			if (acc && sensor_ready) begin
				tick_count_q <= hit ? '0 : tick_count_q + 1'b1;
			end
			if (acc && hit) begin
				wi_q <= wi_next;
			end
			if (wr_en) begin
				ring_vld_q[addr_s1] <= 1'b1;
				sum_q               <= sum_new;
			end
			if (adv3 && take_s2) begin
				brightness_q <= quot;
			end
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// With WINDOW above one, the entry read for a new request never matches the
	// one written by the request leaving the first stage, as the write index moves on a sample.
	always_ff @(posedge clk) begin
		if (acc) begin
			old_s1     <= ring_mem[wi_q];
			old_vld_s1 <= ring_vld_q[wi_q];
			take_s1    <= hit;
			level_s1   <= level_in;
			addr_s1    <= wi_q;
		end
		if (wr_en) begin
			ring_mem[addr_s1] <= level_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			take_s2 <= take_s1;
			sum_s2  <= sum_new;
		end
		if (adv3) begin
			start_s3 <= take_s2;
			pwm_s3   <= take_s2 ? quot : brightness_q;
		end
	end

	assign out_valid        = vld_s3;
	assign pwm_compare      = pwm_s3;
	assign start_conversion = start_s3;

endmodule

// ===== src/aba_checker.sv =====
// ----------------------------------------------------------------------------
// aba_checker
// Port-level checks of the ambient brightness averager, bound to the top.
// ----------------------------------------------------------------------------
module aba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [aba_pkg::VALUE_W-1:0] pwm_compare,
	input logic                        start_conversion
);
	import aba_pkg::*;

	logic [2:0]         pending_q;
	logic [VALUE_W-1:0] last_pwm_q;
	logic               in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			last_pwm_q <= BRIGHTNESS_RST;
		end else begin
			pending_q <= pending_q + {2'b00, in_acc} - {2'b00, out_acc};
			if (out_acc) begin
				last_pwm_q <= pwm_compare;
			end
		end
	end

	// A stalled result holds its value.
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pwm_compare)
			&& $stable(start_conversion))
		else $error("result changed while stalled");

	// The pipeline holds at most three requests, and a result needs one.
	ap_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3 && (!out_valid || pending_q != 3'd0))
		else $error("request count out of range");

	// An empty block takes a request.
	ap_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> in_ready)
		else $error("empty block refused a request");

	// Without a new sample the brightness repeats the last delivered value.
	ap_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !start_conversion |-> pwm_compare == last_pwm_q)
		else $error("brightness changed without a sample");

endmodule

bind ambient_brightness_averager aba_checker u_aba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.pwm_compare      (pwm_compare),
	.start_conversion (start_conversion)
);

// ===== tb/ambient_brightness_averager_test.sv =====
// ----------------------------------------------------------------------------
// ambient_brightness_averager_test
// Self-checking bench for the brightness averager. It drives PWM ticks and
// register writes over valid/ready handshakes, keeps its own copy of the
// sample ring and tick counter, and checks every compare value and
// conversion start in order of acceptance.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [aba_pkg::VALUE_W-1:0] pwm;
	logic                        started;
} tick_result_t;

class dimming_scoreboard;
	logic [aba_pkg::COUNT_W-1:0] interval;
	logic [aba_pkg::VALUE_W-1:0] floor_level;
	logic [aba_pkg::COUNT_W-1:0] ready_ticks;
	logic [aba_pkg::VALUE_W-1:0] ring [aba_pkg::WINDOW_DEF];
	int                          slot;
	logic [aba_pkg::VALUE_W-1:0] level_now;
	tick_result_t                owed [$];
	int                          mismatches;
	int                          ticks_noted;
	int                          samples_taken;
	int                          reg_writes;

	function new();
		interval      = aba_pkg::SAMPLE_INTERVAL_RST;
		floor_level   = aba_pkg::MIN_BRIGHTNESS_RST;
		ready_ticks   = '0;
		slot          = 0;
		level_now     = aba_pkg::BRIGHTNESS_RST;
		mismatches    = 0;
		ticks_noted   = 0;
		samples_taken = 0;
		reg_writes    = 0;
		foreach (ring[i]) ring[i] = '0;
	endfunction

	function void write_reg(logic [aba_pkg::CFG_IDX_W-1:0] idx,
			logic [aba_pkg::CFG_DATA_W-1:0] data);
		reg_writes++;
		case (idx)
			aba_pkg::REG_SAMPLE_INTERVAL: interval = data;
			aba_pkg::REG_MIN_BRIGHTNESS:  floor_level = data[aba_pkg::VALUE_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_tick(logic rdy, logic [aba_pkg::VALUE_W-1:0] val);
		logic [aba_pkg::COUNT_W-1:0] old_count;
		logic [aba_pkg::VALUE_W-1:0] level;
		int                          sum;
		tick_result_t                res;
		res.started = 1'b0;
		ticks_noted++;
		if (rdy) begin
			old_count = ready_ticks;
			ready_ticks = ready_ticks + 1'b1;
			if (old_count == interval) begin
				ready_ticks = '0;
				level = aba_pkg::VALUE_MAX - val;
				if (level < floor_level)
					level = floor_level;
				ring[slot] = level;
				slot = (slot + 1) % aba_pkg::WINDOW_DEF;
				sum = 0;
				foreach (ring[i]) sum += ring[i];
				sum = sum / aba_pkg::WINDOW_DEF;
				level_now = sum[aba_pkg::VALUE_W-1:0];
				res.started = 1'b1;
				samples_taken++;
			end
		end
		res.pwm = level_now;
		owed.push_back(res);
	endfunction

	function void flag(string msg);
		mismatches++;
		$display("%0t: %s", $time, msg);
	endfunction

	function void check_tick(logic [aba_pkg::VALUE_W-1:0] pwm, logic started);
		tick_result_t want;
		if (owed.size() == 0) begin
			flag($sformatf("result with no tick pending: expected none, actual pwm %0d start %0d",
				pwm, started));
			return;
		end
		want = owed.pop_front();
		if (pwm !== want.pwm)
			flag($sformatf("pwm_compare expected %0d, actual %0d", want.pwm, pwm));
		if (started !== want.started)
			flag($sformatf("start_conversion expected %0d, actual %0d", want.started, started));
	endfunction
endclass

module ambient_brightness_averager_test;
	import aba_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [COUNT_W-1:0]   COUNT_MAX   = 16'hFFFF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 12;
	localparam int LONG_HOLD   = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  sensor_ready;
	logic [VALUE_W-1:0]    sensor_value;
	logic                  out_valid;
	logic                  out_ready;
	logic [VALUE_W-1:0]    pwm_compare;
	logic                  start_conversion;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int rx_hold_left = 0;
	int cycle_count  = 0;

	dimming_scoreboard sb = new();

	ambient_brightness_averager dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sensor_ready     (sensor_ready),
		.sensor_value     (sensor_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pwm_compare      (pwm_compare),
		.start_conversion (start_conversion)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d ticks still owed.", cycle_count,
			sb.owed.size());
		$display("TB_ERROR");
		$finish;
	end

	// Output side: random stalls, or a long hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_tick(pwm_compare, start_conversion);
		end
	end

	task automatic send_tick(input logic rdy, input logic [VALUE_W-1:0] val);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		sensor_ready <= rdy;
		sensor_value <= val;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(rdy, val);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Registers change only with nothing in flight. The upper data bits of the
	// floor write and the spare indexes carry noise that must be ignored.
	task automatic reconfigure(input logic [COUNT_W-1:0] interval,
			input logic [VALUE_W-1:0] floor_level);
		logic [VALUE_W-1:0]    upper;
		logic [CFG_DATA_W-1:0] spare_data;
		upper      = VALUE_W'($urandom_range(0, 255));
		spare_data = CFG_DATA_W'($urandom_range(0, 65535));
		drain();
		write_reg(REG_SAMPLE_INTERVAL, interval);
		write_reg(REG_MIN_BRIGHTNESS, {upper, floor_level});
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, spare_data);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_block(input int n_settings, input int per_setting, input bit with_hold);
		logic [COUNT_W-1:0] interval;
		logic [VALUE_W-1:0] floor_level;
		logic               rdy;
		logic [VALUE_W-1:0] val;
		for (int s = 0; s < n_settings; s++) begin
			// Finish the running count so a smaller interval cannot force a wrap.
			while (sb.ready_ticks != 0)
				send_tick(1'b1, VALUE_W'($urandom_range(0, 255)));
			case ($urandom_range(0, 3))
				0: interval = '0;
				1: interval = COUNT_W'($urandom_range(1, 3));
				default: interval = COUNT_W'($urandom_range(4, 12));
			endcase
			case ($urandom_range(0, 5))
				0: floor_level = '0;
				1: floor_level = VALUE_MAX;
				default: floor_level = VALUE_W'($urandom_range(0, 255));
			endcase
			reconfigure(interval, floor_level);
			if (with_hold && s == 0)
				rx_hold_left = LONG_HOLD;
			for (int i = 0; i < per_setting; i++) begin
				rdy = ($urandom_range(0, 99) < 80);
				case ($urandom_range(0, 9))
					0: val = '0;
					1: val = VALUE_MAX;
					default: val = VALUE_W'($urandom_range(0, 255));
				endcase
				send_tick(rdy, val);
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		sensor_ready = 1'b0;
		sensor_value = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct  = 12;
		rx_stall_pct = 48;

		// Reset settings: idle ticks hold, ready ticks count far below the interval.
		send_tick(1'b0, 8'h00);
		send_tick(1'b1, 8'hFF);
		send_tick(1'b0, 8'hFF);
		send_tick(1'b1, 8'h00);
		// Interval equal to the count so far; the first average still holds zeros.
		reconfigure(16'd2, 8'h00);
		send_tick(1'b1, 8'h00);
		// Every ready tick samples, no floor.
		reconfigure(16'd0, 8'h00);
		send_tick(1'b1, 8'h00);
		send_tick(1'b1, 8'hFF);
		send_tick(1'b1, 8'h01);
		send_tick(1'b0, 8'h55);
		send_tick(1'b1, 8'h80);
		// Floor at its maximum lifts every inverted reading.
		reconfigure(16'd0, VALUE_MAX);
		send_tick(1'b1, 8'h00);
		send_tick(1'b1, 8'hFF);
		send_tick(1'b1, 8'h7F);
		// Mid floor: one reading below it, one above.
		reconfigure(16'd0, 8'h40);
		send_tick(1'b1, 8'hF0);
		send_tick(1'b1, 8'h10);

		random_block(3, 140, 1'b1);
		tx_idle_pct  = 48;
		rx_stall_pct = 12;
		random_block(3, 140, 1'b1);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		random_block(3, 140, 1'b0);

		// Widest interval: the count climbs far short of it, so nothing samples.
		reconfigure(COUNT_MAX, VALUE_W'($urandom_range(0, 255)));
		repeat (24)
			send_tick($urandom_range(0, 99) < 90, VALUE_W'($urandom_range(0, 255)));

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d ticks, %0d of them sampling, after %0d register writes.",
			sb.ticks_noted, sb.samples_taken, sb.reg_writes);
		$display("Run covered floor extremes, idle and stall mixes, a long output hold-off %s",
			"and a sample interval at the top of its range.");
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
